// ===== src/hot_pkg.sv =====
// Shared types, codes and constants of the haptic overdrive timer.
`timescale 1ns / 1ps

package hot_pkg;

	localparam int TIME_BITS_DEF = 16;
	localparam int DUR_W         = 16;
	localparam int LVL_W         = 5;
	localparam int PHASE_W       = 2;
	localparam int CFG_IDX_W     = 3;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_DUR    = 3'd0,
		REG_MIN_DUR    = 3'd1,
		REG_OD         = 3'd2,
		REG_OD_RANGE   = 3'd3,
		REG_MIN_REST   = 3'd4,
		REG_NORMAL_LVL = 3'd5,
		REG_BOOST_LVL  = 3'd6
	} cfg_reg_t;

	// Drive phase codes.
	localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
	localparam logic [PHASE_W-1:0] PH_BOOST  = 2'd1;
	localparam logic [PHASE_W-1:0] PH_NORMAL = 2'd2;

	// Reset values of the registers.
	localparam logic [DUR_W-1:0] MAX_DUR_RST    = 16'd15000;
	localparam logic [LVL_W-1:0] NORMAL_LVL_RST = 5'd20;
	localparam logic [LVL_W-1:0] BOOST_LVL_RST  = 5'd28;

	// Operand selection of the shared divider.
	localparam logic DIV_SEL_RATIO   = 1'b0;
	localparam logic DIV_SEL_ELAPSED = 1'b1;

	typedef struct packed {
		logic [DUR_W-1:0] max_dur;
		logic [DUR_W-1:0] min_dur;
		logic [DUR_W-1:0] od;
		logic [DUR_W-1:0] od_range;
		logic [DUR_W-1:0] min_rest;
		logic [LVL_W-1:0] normal_lvl;
		logic [LVL_W-1:0] boost_lvl;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic div_start;
		logic div_sel;
		logic q_load;
		logic ov_clear;
		logic ov_load;
		logic apply;
	} dp_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
		logic q_zero;
		logic out_free;
	} dp_status_t;

endpackage

// ===== src/hot_item_if.sv =====
// Input channel carrying requests and ticks.
`timescale 1ns / 1ps

interface hot_item_if import hot_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             action;
	logic [DUR_W-1:0] duration_ms;

	modport source (output valid, output action, output duration_ms, input ready);
	modport sink (input valid, input action, input duration_ms, output ready);
endinterface

// ===== src/hot_result_if.sv =====
// Output channel carrying the drive state after each transaction.
`timescale 1ns / 1ps

interface hot_result_if import hot_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               drive_on;
	logic [LVL_W-1:0]   drive_level;
	logic [PHASE_W-1:0] phase;
	logic [DUR_W-1:0]   remaining_ms;

	modport source (output valid, output drive_on, output drive_level, output phase,
		output remaining_ms, input ready);
	modport sink (input valid, input drive_on, input drive_level, input phase,
		input remaining_ms, output ready);
endinterface

// ===== src/hot_cfg_if.sv =====
// Configuration write channel.
`timescale 1ns / 1ps

interface hot_cfg_if import hot_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DUR_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/hot_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module hot_div #(
	parameter int W = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);

	localparam int CNT_W = $clog2(W + 1);

	logic [W:0]       rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [W:0]       shifted;
	logic [W:0]       trial;

	assign shifted = {rem_q[W-1:0], quo_q[W-1]};
	assign trial   = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial;
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== src/hot_dp.sv =====
// Datapath: drive state, elapsed counters, divider and result register.
`timescale 1ns / 1ps

module hot_dp import hot_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_action,
	input  logic [DUR_W-1:0]   in_duration_ms,
	input  dp_cmd_t            cmd,
	output dp_status_t         status,
	input  logic               out_ready,
	output logic               out_valid,
	output logic               drive_on,
	output logic [LVL_W-1:0]   drive_level,
	output logic [PHASE_W-1:0] phase,
	output logic [DUR_W-1:0]   remaining_ms
);

	localparam int CW = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	typedef struct packed {
		logic [PHASE_W-1:0]   phase;
		logic [DUR_W-1:0]     od_left;
		logic [DUR_W-1:0]     nl_left;
		logic [DUR_W:0]       rem;
		logic [DUR_W-1:0]     last;
		logic                 run;
		logic [TIME_BITS-1:0] ss;
		logic [TIME_BITS-1:0] sp;
		logic [LVL_W-1:0]     lvl;
	} st_t;

	localparam st_t ST_RST = '{phase: PH_IDLE, od_left: '0, nl_left: '0, rem: '0,
		last: '0, run: 1'b0, ss: '0, sp: '0, lvl: NORMAL_LVL_RST};

	st_t                st_q;
	st_t                nxt;
	logic               action_q;
	logic [DUR_W-1:0]   dur_q;
	logic [DUR_W-1:0]   q_q;
	logic [DUR_W-1:0]   ov_q;
	logic               out_valid_q;
	logic               drive_on_q;
	logic [LVL_W-1:0]   drive_level_q;
	logic [PHASE_W-1:0] phase_q;
	logic [DUR_W-1:0]   remaining_q;

	logic [DUR_W-1:0]   v_lo;
	logic [DUR_W-1:0]   v;
	logic [CW-1:0]      ss_c;
	logic [CW-1:0]      sp_c;
	logic [DUR_W-1:0]   ss16;
	logic [DUR_W-1:0]   sp16;
	logic               od_path;
	logic signed [DUR_W:0] half_diff;
	logic               div_done;
	logic [DUR_W-1:0]   div_quot;
	logic [DUR_W-1:0]   div_dividend;
	logic [DUR_W-1:0]   div_divisor;

	function automatic st_t f_go_off(st_t s);
		st_t r;
		r = s;
		r.phase   = PH_IDLE;
		r.od_left = '0;
		r.nl_left = '0;
		if (r.run) begin
			r.run = 1'b0;
			r.sp  = '0;
		end
		return r;
	endfunction

	function automatic st_t f_mark_on(st_t s);
		st_t r;
		r = s;
		if (!r.run) begin
			r.run = 1'b1;
			r.ss  = '0;
		end
		return r;
	endfunction

	function automatic st_t f_end_od(st_t s, logic [LVL_W-1:0] normal);
		st_t r;
		r = s;
		r.lvl     = normal;
		r.od_left = '0;
		if (!r.rem[DUR_W] && (r.rem != '0)) begin
			r.phase   = PH_NORMAL;
			r.nl_left = r.rem[DUR_W-1:0];
		end else begin
			r = f_go_off(r);
		end
		return r;
	endfunction

	function automatic st_t f_start_normal(st_t s, logic [DUR_W:0] t,
		logic [LVL_W-1:0] normal);
		st_t r;
		r = s;
		r.lvl     = normal;
		r         = f_mark_on(r);
		r.od_left = '0;
		if (t == '0) begin
			r = f_go_off(r);
		end else begin
			r.phase   = PH_NORMAL;
			r.nl_left = t[DUR_W-1:0];
		end
		return r;
	endfunction

	function automatic st_t f_start_od(st_t s, logic [DUR_W-1:0] t,
		logic [LVL_W-1:0] boost, logic [LVL_W-1:0] normal);
		st_t r;
		r = s;
		r.lvl     = boost;
		r         = f_mark_on(r);
		r.nl_left = '0;
		if (t == '0) begin
			r = f_end_od(r, normal);
		end else begin
			r.phase   = PH_BOOST;
			r.od_left = t;
		end
		return r;
	endfunction

	// Clamp and the comparisons that pick the branch of a request.
	assign v_lo    = (dur_q < cfg.min_dur) ? cfg.min_dur : dur_q;
	assign v       = (v_lo > cfg.max_dur) ? cfg.max_dur : v_lo;
	assign ss_c    = CW'(st_q.ss);
	assign sp_c    = CW'(st_q.sp);
	assign ss16    = DUR_W'(st_q.ss);
	assign sp16    = DUR_W'(st_q.sp);
	assign od_path = (cfg.od != '0) && (v <= cfg.od_range);
	assign half_diff = $signed({1'b0, v}) - $signed({1'b0, ov_q});

	always_comb begin
		nxt = st_q;
		if (action_q) begin
			if (nxt.ss != TIME_MAX) nxt.ss = nxt.ss + 1'b1;
			if (nxt.sp != TIME_MAX) nxt.sp = nxt.sp + 1'b1;
			case (nxt.phase)
				PH_BOOST: begin
					if (nxt.od_left != '0) nxt.od_left = nxt.od_left - 1'b1;
					if (nxt.od_left == '0) nxt = f_end_od(nxt, cfg.normal_lvl);
				end
				PH_NORMAL: begin
					if (nxt.nl_left != '0) nxt.nl_left = nxt.nl_left - 1'b1;
					if (nxt.nl_left == '0) nxt = f_go_off(nxt);
				end
				default: ;
			endcase
		end else if (dur_q == '0) begin
			if (nxt.last > cfg.min_dur) nxt = f_go_off(nxt);
		end else begin
			nxt.last = v;
			if (!od_path) begin
				nxt = f_start_normal(nxt, {1'b0, v}, cfg.normal_lvl);
			end else begin
				nxt.rem = {1'b0, v} - {1'b0, cfg.od};
				if (nxt.run) begin
					if (ss_c > CW'(cfg.min_dur)) begin
						nxt = f_start_normal(nxt, {1'b0, dur_q}, cfg.normal_lvl);
					end else if (CW'(cfg.od) > ss_c) begin
						nxt.rem = {1'b0, dur_q};
						nxt = f_start_od(nxt, cfg.od - ss16, cfg.boost_lvl, cfg.normal_lvl);
					end else begin
						nxt = f_start_normal(nxt, {1'b0, v} - {1'b0, ss16}, cfg.normal_lvl);
					end
				end else begin
					if (sp_c > CW'(cfg.min_rest)) begin
						nxt = f_start_od(nxt, cfg.od, cfg.boost_lvl, cfg.normal_lvl);
					end else begin
						nxt.rem = half_diff >>> 1;
						nxt = f_start_od(nxt, ov_q, cfg.boost_lvl, cfg.normal_lvl);
					end
				end
			end
		end
	end

	// Shared divider: the rest-to-overdrive ratio, then elapsed over a nonzero ratio.
	assign div_dividend = (cmd.div_sel == DIV_SEL_ELAPSED) ? sp16 : cfg.min_rest;
	assign div_divisor  = (cmd.div_sel == DIV_SEL_ELAPSED) ? q_q : cfg.od;

	hot_div #(
		.W (DUR_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.apply) begin
				st_q        <= nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= in_action;
			dur_q    <= in_duration_ms;
		end
		if (cmd.q_load) q_q <= div_quot;
		if (cmd.ov_clear) begin
			ov_q <= '0;
		end else if (cmd.ov_load) begin
			ov_q <= div_quot >> 1;
		end
		if (cmd.apply) begin
			drive_on_q    <= (nxt.phase != PH_IDLE);
			drive_level_q <= (nxt.phase != PH_IDLE) ? nxt.lvl : '0;
			phase_q       <= nxt.phase;
			remaining_q   <= (nxt.phase == PH_NORMAL) ? nxt.nl_left : '0;
		end
	end

	assign status.need_div = !action_q && (dur_q != '0) && od_path && !st_q.run
		&& !(sp_c > CW'(cfg.min_rest));
	assign status.div_done = div_done;
	assign status.q_zero   = (div_quot == '0);
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign drive_on     = drive_on_q;
	assign drive_level  = drive_level_q;
	assign phase        = phase_q;
	assign remaining_ms = remaining_q;

endmodule

// ===== src/hot_ctrl.sv =====
// Controller state machine sequencing capture, division and update.
`timescale 1ns / 1ps

module hot_ctrl import hot_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_CALC   = 6'b000010,
		S_DIV1   = 6'b000100,
		S_DIV2S  = 6'b001000,
		S_DIV2   = 6'b010000,
		S_APPLY  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_CALC;
				end
			end
			S_CALC: begin
				if (status.need_div) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_SEL_RATIO;
					state_d       = S_DIV1;
				end else begin
					state_d = S_APPLY;
				end
			end
			S_DIV1: begin
				if (status.div_done) begin
					cmd.q_load = 1'b1;
					if (status.q_zero) begin
						cmd.ov_clear = 1'b1;
						state_d      = S_APPLY;
					end else begin
						state_d = S_DIV2S;
					end
				end
			end
			S_DIV2S: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_SEL_ELAPSED;
				state_d       = S_DIV2;
			end
			S_DIV2: begin
				cmd.div_sel = DIV_SEL_ELAPSED;
				if (status.div_done) begin
					cmd.ov_load = 1'b1;
					state_d     = S_APPLY;
				end
			end
			S_APPLY: begin
				if (status.out_free) begin
					cmd.apply = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== src/haptic_overdrive_timer_top.sv =====
// Top level of the haptic overdrive timer: configuration registers and block wiring.
`timescale 1ns / 1ps

// The block sequences a vibration motor. Each transaction on the item channel is
// either a one millisecond tick (action = 1) or a duration request (action = 0,
// duration_ms = 0 meaning stop). Every item yields exactly one transaction on the
// result channel that reports the drive state after the item: drive_on,
// drive_level, phase (idle, overdrive, normal) and the normal-phase time left.
// Seven registers are written through the cfg channel, which is always ready;
// write them only while no item is in flight. Unused indexes are ignored.
// Items are handled one at a time. A tick or a request that needs no scaling
// goes from capture through the CALC state to APPLY. An overdrive request from
// rest inside the minimum rest window runs the shared 16-bit serial divider (one
// quotient bit per cycle): once, for the rest-to-overdrive ratio, when that ratio
// is zero, otherwise twice, the second time for the elapsed rest over the ratio.
// The result sits in an output register, so a new item is accepted while an
// earlier result still waits; if the receiver stalls, the block holds the next
// result in APPLY and takes no more items until the register frees.
// Reset (arst_n low) returns to idle, clears the elapsed counters and restores
// the register defaults; no clearing pass is needed.
module haptic_overdrive_timer_top import hot_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	hot_item_if.sink     item,
	hot_result_if.source result,
	hot_cfg_if.sink      cfg
);

	cfg_t       cfg_q;
	dp_cmd_t    cmd;
	dp_status_t status;

	// Configuration registers, one write per transaction.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{max_dur: MAX_DUR_RST, min_dur: '0, od: '0, od_range: '0,
				min_rest: '0, normal_lvl: NORMAL_LVL_RST, boost_lvl: BOOST_LVL_RST};
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_MAX_DUR:    cfg_q.max_dur    <= cfg.data;
				REG_MIN_DUR:    cfg_q.min_dur    <= cfg.data;
				REG_OD:         cfg_q.od         <= cfg.data;
				REG_OD_RANGE:   cfg_q.od_range   <= cfg.data;
				REG_MIN_REST:   cfg_q.min_rest   <= cfg.data;
				REG_NORMAL_LVL: cfg_q.normal_lvl <= cfg.data[LVL_W-1:0];
				REG_BOOST_LVL:  cfg_q.boost_lvl  <= cfg.data[LVL_W-1:0];
				default: ;
			endcase
		end
	end

	// The controller decides when to capture, divide and commit.
	hot_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the motor state and the result register.
	hot_dp #(
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.in_action      (item.action),
		.in_duration_ms (item.duration_ms),
		.cmd            (cmd),
		.status         (status),
		.out_ready      (result.ready),
		.out_valid      (result.valid),
		.drive_on       (result.drive_on),
		.drive_level    (result.drive_level),
		.phase          (result.phase),
		.remaining_ms   (result.remaining_ms)
	);

endmodule
